// ===== rtl/ipv4fhg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header generator - shared package
// Constants, payload word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ipv4fhg_pkg;

    localparam int unsigned LINK_MTU          = 1500;
    localparam int unsigned MIN_FRAME_PAYLOAD = 46;
    localparam int unsigned HDR_BYTES         = 20;
    localparam int unsigned MAX_RESULTS       = 45;
    localparam int unsigned MAX_PAYLOAD       = 32'hFFFF - HDR_BYTES;
    localparam int unsigned FRAG_DATA         = (LINK_MTU - HDR_BYTES) & ~32'd7;
    localparam int unsigned MAX_FRAG_TOTAL    = MAX_RESULTS * FRAG_DATA;

    localparam logic [7:0]  VER_IHL  = 8'h45;
    localparam logic [15:0] ONES_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_IP       = 2'd0;
    localparam logic [1:0] CFG_TIME_TO_LIVE    = 2'd1;
    localparam logic [1:0] CFG_TYPE_OF_SERVICE = 2'd2;

    typedef struct packed {
        logic [15:0] packet_id;
        logic [15:0] payload_length;
        logic [7:0]  protocol;
        logic [31:0] dest_ip;
    } t_req;

    typedef struct packed {
        logic [10:0] total_length;
        logic [15:0] flags_offset;
        logic [15:0] header_checksum;
        logic [10:0] frame_size;
        logic        last_fragment;
        logic        rejected;
    } t_desc;

    typedef struct packed {
        logic load;
        logic calc;
        logic sum;
        logic finish;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/ipv4fhg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header generator - controller
// Sequences load, per-fragment calculation, checksum fold and hand-off.
// ----------------------------------------------------------------------------
module ipv4fhg_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output ipv4fhg_pkg::t_cmd o_cmd,
    input  ipv4fhg_pkg::t_sts i_sts
);
    import ipv4fhg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_SUM  = 5'b00100,
        S_FIN  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.advance = 1'b1;
                    n_state       = i_sts.last ? S_IDLE : S_CALC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ipv4fhg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header generator - datapath
// Config registers, request classification, fragment sizing and checksum.
// ----------------------------------------------------------------------------
module ipv4fhg_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [31:0]        i_cfg_wdata,
    input  ipv4fhg_pkg::t_req  i_req,
    input  ipv4fhg_pkg::t_cmd  i_cmd,
    output ipv4fhg_pkg::t_sts  o_sts,
    output ipv4fhg_pkg::t_desc o_desc
);
    import ipv4fhg_pkg::*;

    logic [31:0] r_source_ip;
    logic [7:0]  r_ttl;
    logic [7:0]  r_tos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_ip <= '0;
            r_ttl       <= 8'd64;
            r_tos       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_IP:       r_source_ip <= i_cfg_wdata;
                CFG_TIME_TO_LIVE:    r_ttl       <= i_cfg_wdata[7:0];
                CFG_TYPE_OF_SERVICE: r_tos       <= i_cfg_wdata[7:0];
                default:             ;
            endcase
        end
    end

    // request context
    logic [18:0] r_base;     // sum of the header words fixed for the request
    logic [15:0] r_left;
    logic [15:0] r_off;
    logic        r_single;
    logic        r_rej;

    // per-word stage
    logic [15:0] r_tl;
    logic [15:0] r_fo;
    logic [15:0] r_fr;
    logic [15:0] r_sz;
    logic        r_last;
    logic [19:0] r_sum;
    t_desc       r_desc;

    logic [16:0] tl_in;
    logic        fits;
    logic        n_rej;
    logic [18:0] n_base;
    logic        more;
    logic [15:0] sz;
    logic [15:0] tl;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        tl_in  = {1'b0, i_req.payload_length} + 17'(HDR_BYTES);
        fits   = tl_in <= 17'(LINK_MTU);
        n_rej  = (32'(i_req.payload_length) > MAX_PAYLOAD) ||
                 (!fits && (32'(i_req.payload_length) > MAX_FRAG_TOTAL));
        n_base = 19'({VER_IHL, r_tos}) + 19'(i_req.packet_id)
               + 19'({r_ttl, i_req.protocol})
               + 19'(r_source_ip[31:16]) + 19'(r_source_ip[15:0])
               + 19'(i_req.dest_ip[31:16]) + 19'(i_req.dest_ip[15:0]);

        more  = !r_single && (32'(r_left) > FRAG_DATA);
        sz    = more ? 16'(FRAG_DATA) : r_left;
        tl    = sz + 16'(HDR_BYTES);

        // end-around carry, twice is enough for a 20-bit sum
        fold1 = 17'(r_sum[15:0]) + 17'(r_sum[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= n_base;
            r_left   <= i_req.payload_length;
            r_off    <= '0;
            r_single <= fits;
            r_rej    <= n_rej;
        end
        if (i_cmd.calc) begin
            r_sz <= sz;
            if (r_rej) begin
                r_tl   <= '0;
                r_fo   <= '0;
                r_fr   <= '0;
                r_last <= 1'b1;
            end else begin
                r_tl   <= tl;
                r_fo   <= {2'b00, more, r_off[15:3]};
                r_fr   <= (32'(tl) < MIN_FRAME_PAYLOAD) ? 16'(MIN_FRAME_PAYLOAD) : tl;
                r_last <= !more;
            end
        end
        if (i_cmd.sum) begin
            r_sum <= 20'(r_base) + 20'(r_tl) + 20'(r_fo);
        end
        if (i_cmd.finish) begin
            r_desc.total_length    <= r_tl[10:0];
            r_desc.flags_offset    <= r_fo;
            r_desc.header_checksum <= r_rej ? 16'h0000 : (fold2 ^ ONES_MAX);
            r_desc.frame_size      <= r_fr[10:0];
            r_desc.last_fragment   <= r_last;
            r_desc.rejected        <= r_rej;
        end
        if (i_cmd.advance) begin
            r_left <= r_left - r_sz;
            r_off  <= r_off + r_sz;
        end
    end

    assign o_sts.last = r_last;
    assign o_desc     = r_desc;

endmodule

`default_nettype wire

// ===== rtl/ipv4_fragment_header_gen_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 fragment header generator - top level
// A request word (id, payload length, protocol, destination) goes in on the
// input channel; one header descriptor word per fragment comes out, the last
// one flagged. Payload above the IPv4 limit yields one rejected word.
// Both channels are valid/stall: a word moves when valid is high and stall
// is low. Input stall stays high from acceptance until the final descriptor
// of that request has been taken.
// Each descriptor takes the controller steps calculate, sum, fold and
// present; a further fragment starts once the previous one is taken. A
// request thus occupies the block for four steps per fragment plus the
// receiver's stall time and the idle state in which the next request is
// taken. The four controller steps per descriptor set this occupancy.
// A stalled descriptor is held unchanged in the output register.
// Reset (synchronous, active low) returns to idle and loads the config
// registers with source 0, TTL 64, TOS 0. The user must make config
// writes only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_gen_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [31:0]        i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  ipv4fhg_pkg::t_req  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ipv4fhg_pkg::t_desc o_out_word
);
    import ipv4fhg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ipv4fhg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ipv4fhg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_desc      (o_out_word)
    );

endmodule

`default_nettype wire
